FILE: rtl/btas_pkg.sv
// btas_pkg: shared types, codes and microcode table for the block-transfer
// address sequencer. No dependencies; used by btas_if.sv and the top level.
`default_nettype none

package btas_pkg;

  localparam logic [1:0] MODE_LOAD       = 2'd0;
  localparam logic [1:0] MODE_STORE      = 2'd1;
  localparam logic [1:0] MODE_USER_LOAD  = 2'd2;
  localparam logic [1:0] MODE_USER_STORE = 2'd3;

  localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;
  localparam logic [31:0] WORD_STEP  = 32'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  base_register;
    logic [31:0] base_address;
    logic [15:0] register_list;
    logic        increment;
    logic        before_req;
    logic        writeback;
  } req_t;

  typedef struct packed {
    logic [3:0]  reg_index;
    logic [31:0] address;
    logic        is_load;
    logic        user_bank;
    logic        branch_to_loaded;
    logic        restore_status;
    logic        transfer_valid;
    logic        wb_valid;
    logic [3:0]  wb_register;
    logic [31:0] wb_value;
    logic        last;
  } xfer_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_WAIT  = 2'd0;
  localparam step_t STEP_INIT  = 2'd1;
  localparam step_t STEP_SCAN  = 2'd2;
  localparam step_t STEP_EMPTY = 2'd3;
  localparam int    NUM_STEPS  = 4;

  typedef enum logic [1:0] {
    COND_IN_FIRE,
    COND_LIST_EMPTY,
    COND_LAST_XFER,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  init;
    logic  scan;
    logic  emit_empty;
    cond_e cond;
    step_t next_true;
    step_t next_false;
  } ctrl_t;

  // one control word per step
  localparam ctrl_t UCODE [NUM_STEPS] = '{
    '{in_ready: 1'b1, init: 1'b0, scan: 1'b0, emit_empty: 1'b0,
      cond: COND_IN_FIRE, next_true: STEP_INIT, next_false: STEP_WAIT},
    '{in_ready: 1'b0, init: 1'b1, scan: 1'b0, emit_empty: 1'b0,
      cond: COND_LIST_EMPTY, next_true: STEP_EMPTY, next_false: STEP_SCAN},
    '{in_ready: 1'b0, init: 1'b0, scan: 1'b1, emit_empty: 1'b0,
      cond: COND_LAST_XFER, next_true: STEP_WAIT, next_false: STEP_SCAN},
    '{in_ready: 1'b0, init: 1'b0, scan: 1'b0, emit_empty: 1'b1,
      cond: COND_OUT_FREE, next_true: STEP_WAIT, next_false: STEP_EMPTY}
  };

endpackage

`default_nettype wire

FILE: rtl/btas_if.sv
// btas_req_if and btas_xfer_if: valid/ready channels for request and
// transfer beats. Depends on btas_pkg for the payload types.
`default_nettype none

interface btas_req_if import btas_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btas_xfer_if import btas_pkg::*; ();
  logic  valid;
  logic  ready;
  xfer_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/block_transfer_address_sequencer_top.sv
// block_transfer_address_sequencer_top: microcoded sequencer that turns one
// load/store-multiple request into one transfer beat per listed register, or
// one empty last beat for an empty list. The wait step captures the request,
// init sets the address and scan start, and scan registers each beat. Scan
// steps one register position per cycle but holds at a listed register while
// the output is stalled; a new request is accepted only after the last beat.
// reset: step counter returns to the wait step and the output beat is dropped
`default_nettype none

module block_transfer_address_sequencer_top import btas_pkg::*; #(
  parameter int REGISTER_COUNT = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  btas_req_if.sink          req_i,
  btas_xfer_if.source       xfer_o
);

  localparam int RW = $clog2(REGISTER_COUNT);
  localparam int CW = $clog2(REGISTER_COUNT + 1);
  localparam int RC = REGISTER_COUNT;
  localparam logic [RW-1:0] PC_IDX = RW'(REGISTER_COUNT - 1);

  step_t          upc_q, upc_d;
  ctrl_t          cw;
  logic [1:0]     mode_q;
  logic [3:0]     base_reg_q;
  logic [31:0]    base_q;
  logic           up_q, before_q, do_wb_q;
  logic [RC-1:0]  pend_q;
  logic [RW-1:0]  r_q;
  logic [31:0]    addr_q;
  logic [CW-1:0]  count_q;
  logic           out_valid_q;
  xfer_t          out_q, out_d;

  logic [RC+15:0] list_ext;
  logic [RC-1:0]  list_in, rbit, rest;
  logic [RW+3:0]  r_ext;
  logic [CW-1:0]  count_next;
  logic [31:0]    aligned, addr_first, addr_next, delta, wb_sum;
  logic           bit_set, last_x, out_free, emit_x, emit_e, in_fire, cond_ok;
  logic           is_load, is_user, is_pc, wb_req_ok, fire_last;

  assign cw = UCODE[upc_q];

  assign list_ext = {{RC{1'b0}}, req_i.data.register_list};
  assign list_in  = list_ext[RC-1:0];

  assign in_fire  = cw.in_ready && req_i.valid;
  assign out_free = !out_valid_q || xfer_o.ready;
  assign rbit     = {{(RC-1){1'b0}}, 1'b1} << r_q;
  assign bit_set  = |(pend_q & rbit);
  assign rest     = pend_q & ~rbit;
  assign last_x   = (rest == '0);
  assign emit_x   = cw.scan && bit_set && out_free;
  assign emit_e   = cw.emit_empty && out_free;
  assign fire_last = emit_x && last_x;

  always_comb begin
    case (cw.cond)
      COND_IN_FIRE:    cond_ok = in_fire;
      COND_LIST_EMPTY: cond_ok = (pend_q == '0);
      COND_LAST_XFER:  cond_ok = fire_last;
      COND_OUT_FREE:   cond_ok = out_free;
      default:         cond_ok = 1'b0;
    endcase
    upc_d = cond_ok ? cw.next_true : cw.next_false;
  end

  assign is_load = (mode_q == MODE_LOAD) || (mode_q == MODE_USER_LOAD);
  assign is_user = (mode_q == MODE_USER_LOAD) || (mode_q == MODE_USER_STORE);
  assign is_pc   = (r_q == PC_IDX);
  assign r_ext   = {4'b0000, r_q};

  assign aligned    = base_q & ALIGN_MASK;
  assign addr_first = !before_q ? aligned : (up_q ? aligned + WORD_STEP : aligned - WORD_STEP);
  assign addr_next  = up_q ? addr_q + WORD_STEP : addr_q - WORD_STEP;
  assign count_next = emit_x ? count_q + CW'(1) : count_q;
  assign delta      = {{(30 - CW){1'b0}}, count_next, 2'b00};
  assign wb_sum     = up_q ? base_q + delta : base_q - delta;

  // writeback rule per mode, pc bit taken from the incoming list
  always_comb begin
    case (req_i.data.mode)
      MODE_USER_STORE: wb_req_ok = 1'b0;
      MODE_USER_LOAD:  wb_req_ok = req_i.data.writeback && list_in[RC-1];
      default:         wb_req_ok = req_i.data.writeback;
    endcase
  end

  always_comb begin
    out_d                  = '0;
    out_d.is_load          = is_load;
    out_d.user_bank        = is_user;
    out_d.last             = emit_e || last_x;
    if (emit_x) begin
      out_d.reg_index        = r_ext[3:0];
      out_d.address          = addr_q;
      out_d.branch_to_loaded = is_load && is_pc;
      out_d.restore_status   = is_load && is_user && is_pc;
      out_d.transfer_valid   = 1'b1;
    end
    if (do_wb_q && out_d.last) begin
      out_d.wb_valid    = 1'b1;
      out_d.wb_register = base_reg_q;
      out_d.wb_value    = wb_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= STEP_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (emit_x || emit_e) begin
        out_valid_q <= 1'b1;
      end else if (xfer_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q     <= req_i.data.mode;
      base_reg_q <= req_i.data.base_register;
      base_q     <= req_i.data.base_address;
      up_q       <= req_i.data.increment;
      before_q   <= req_i.data.before_req;
      do_wb_q    <= wb_req_ok;
      pend_q     <= list_in;
    end
    if (cw.init) begin
      addr_q  <= addr_first;
      r_q     <= up_q ? '0 : PC_IDX;
      count_q <= '0;
    end
    if (cw.scan && (!bit_set || emit_x)) begin
      r_q <= up_q ? r_q + RW'(1) : r_q - RW'(1);
    end
    if (emit_x) begin
      pend_q  <= rest;
      addr_q  <= addr_next;
      count_q <= count_next;
    end
    if (emit_x || emit_e) begin
      out_q <= out_d;
    end
  end

  assign req_i.ready  = cw.in_ready;
  assign xfer_o.valid = out_valid_q;
  assign xfer_o.data  = out_q;

`ifndef SYNTHESIS
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == STEP_SCAN) |-> (pend_q != '0))
    else $error("scan step entered with no pending registers");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == STEP_SCAN) |-> (($countones(pend_q) + count_q) <= 16))
    else $error("transfer count exceeds list size");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_last |=> (upc_q == STEP_WAIT) && out_valid_q && xfer_o.data.last)
    else $error("last transfer did not end the request");

  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_e |=> out_valid_q && !xfer_o.data.transfer_valid && xfer_o.data.last)
    else $error("empty list beat malformed");
`endif

endmodule

`default_nettype wire
